>>> src/three_phase_duty_modulator_unit_assert.svh
// Assertion macros for the three-phase duty modulator checker.
// Depends on nothing; taken in by the checker file through an include.
`ifndef THREE_PHASE_DUTY_MODULATOR_UNIT_ASSERT_SVH
`define THREE_PHASE_DUTY_MODULATOR_UNIT_ASSERT_SVH

// Consequent checked a fixed number of cycles after the antecedent.
`define TPDM_ASSERT_DELAY(lbl, clk, rst_n, a, n, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> ##n (b)) \
        else $error("tpdm delayed check failed");

// Consequent checked in the same cycle as the antecedent.
`define TPDM_ASSERT_SAME(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("tpdm same-cycle check failed");

`endif

>>> src/tpdm_pkg.sv
// Package for the three-phase duty modulator: port word types, stage control
// struct and fixed constants. No dependencies.
`timescale 1ns / 1ps

package tpdm_pkg;

    // sqrt(3)/2 in Q0.31, rounded
    localparam logic [31:0] SQ3H_Q31 = 32'd1859775393;

    // Latency from accepted start to done strobe, in cycles
    localparam int unsigned LATENCY = 4;

    typedef struct packed {
        logic signed [15:0] voltage_alpha;
        logic signed [15:0] voltage_beta;
    } voltage_t;

    typedef struct packed {
        logic [14:0] duty_u;
        logic [14:0] duty_v;
        logic [14:0] duty_w;
    } duty_t;

    typedef struct packed {
        logic valid;
        logic mode;
    } stage_ctrl_t;

endpackage

>>> src/tpdm_clarke.sv
// Inverse Clarke stages: input scaling, beta*sqrt(3)/2 product, phase sums.
// Depends on tpdm_pkg.
`timescale 1ns / 1ps

module tpdm_clarke #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tpdm_pkg::stage_ctrl_t         in_ctrl,
    input  tpdm_pkg::voltage_t            vec,
    output tpdm_pkg::stage_ctrl_t         out_ctrl,
    output logic signed [DATA_WIDTH-1:0]  ph_u,
    output logic signed [DATA_WIDTH-1:0]  ph_v,
    output logic signed [DATA_WIDTH-1:0]  ph_w
);

    localparam int DW = DATA_WIDTH;
    localparam int UP = (DW >= 16) ? DW - 16 : 0;
    localparam int DN = (DW >= 16) ? 0 : 16 - DW;
    localparam logic [33:0] K_RND =
        ((34'(tpdm_pkg::SQ3H_Q31) << 1) >> (32 - DW)) + 34'd1;
    localparam logic signed [DW-1:0] K = DW'(K_RND >> 1);
    localparam logic signed [DW+1:0] SMAX_X = {3'b000, {(DW-1){1'b1}}};
    localparam logic signed [DW+1:0] SMIN_X = {3'b111, {(DW-1){1'b0}}};

    function automatic logic signed [DW-1:0] sat(input logic signed [DW+1:0] x);
        logic signed [DW+1:0] y;
        begin
            if (x > SMAX_X)
            begin
                y = SMAX_X;
            end
            else if (x < SMIN_X)
            begin
                y = SMIN_X;
            end
            else
            begin
                y = x;
            end
            return DW'(y);
        end
    endfunction

    logic signed [DW-1:0]   alpha_s;
    logic signed [DW-1:0]   beta_s;
    logic signed [2*DW-1:0] prod;

    tpdm_pkg::stage_ctrl_t  s1_ctrl_reg;
    logic signed [DW-1:0]   s1_alpha_reg;
    logic signed [2*DW-1:0] s1_prod_reg;

    logic signed [DW+1:0]   bt_x;
    logic signed [DW+1:0]   ha_x;
    logic signed [DW-1:0]   v_next;
    logic signed [DW-1:0]   w_next;

    tpdm_pkg::stage_ctrl_t  s2_ctrl_reg;
    logic signed [DW-1:0]   s2_u_reg;
    logic signed [DW-1:0]   s2_v_reg;
    logic signed [DW-1:0]   s2_w_reg;

    // Rescale Q1.15 to the internal width
    assign alpha_s = DW'(vec.voltage_alpha >>> DN) <<< UP;
    assign beta_s  = DW'(vec.voltage_beta >>> DN) <<< UP;
    assign prod    = beta_s * K;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctrl_reg <= '0;
            s2_ctrl_reg <= '0;
        end
        else
        begin
            s1_ctrl_reg <= in_ctrl;
            s2_ctrl_reg <= s1_ctrl_reg;
        end
    end

    // Half of alpha is a floor shift; the product truncates by DW-1
    assign bt_x   = (DW+2)'(s1_prod_reg >>> (DW - 1));
    assign ha_x   = (DW+2)'(s1_alpha_reg >>> 1);
    assign v_next = sat(bt_x - ha_x);
    assign w_next = sat(-bt_x - ha_x);

    always_ff @(posedge clk)
    begin
        s1_alpha_reg <= alpha_s;
        s1_prod_reg  <= prod;
        s2_u_reg     <= s1_alpha_reg;
        s2_v_reg     <= v_next;
        s2_w_reg     <= w_next;
    end

    assign out_ctrl = s2_ctrl_reg;
    assign ph_u     = s2_u_reg;
    assign ph_v     = s2_v_reg;
    assign ph_w     = s2_w_reg;

endmodule

>>> src/tpdm_inject.sv
// Common-mode offset stage: min/max of the three phases and -(max+min)/2.
// Depends on tpdm_pkg.
`timescale 1ns / 1ps

module tpdm_inject #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tpdm_pkg::stage_ctrl_t         in_ctrl,
    input  logic signed [DATA_WIDTH-1:0]  ph_u,
    input  logic signed [DATA_WIDTH-1:0]  ph_v,
    input  logic signed [DATA_WIDTH-1:0]  ph_w,
    output tpdm_pkg::stage_ctrl_t         out_ctrl,
    output logic signed [DATA_WIDTH-1:0]  out_u,
    output logic signed [DATA_WIDTH-1:0]  out_v,
    output logic signed [DATA_WIDTH-1:0]  out_w,
    output logic signed [DATA_WIDTH-1:0]  offset
);

    localparam int DW = DATA_WIDTH;
    localparam logic signed [DW+1:0] SMAX_X = {3'b000, {(DW-1){1'b1}}};
    localparam logic signed [DW+1:0] SMIN_X = {3'b111, {(DW-1){1'b0}}};

    function automatic logic signed [DW-1:0] sat(input logic signed [DW+1:0] x);
        logic signed [DW+1:0] y;
        begin
            if (x > SMAX_X)
            begin
                y = SMAX_X;
            end
            else if (x < SMIN_X)
            begin
                y = SMIN_X;
            end
            else
            begin
                y = x;
            end
            return DW'(y);
        end
    endfunction

    logic signed [DW-1:0]  mx_a;
    logic signed [DW-1:0]  mn_a;
    logic signed [DW-1:0]  mx;
    logic signed [DW-1:0]  mn;
    logic signed [DW-1:0]  mid;
    logic signed [DW-1:0]  offset_next;

    tpdm_pkg::stage_ctrl_t s3_ctrl_reg;
    logic signed [DW-1:0]  s3_u_reg;
    logic signed [DW-1:0]  s3_v_reg;
    logic signed [DW-1:0]  s3_w_reg;
    logic signed [DW-1:0]  s3_offset_reg;

    assign mx_a = (ph_v > ph_u) ? ph_v : ph_u;
    assign mn_a = (ph_v < ph_u) ? ph_v : ph_u;
    assign mx   = (ph_w > mx_a) ? ph_w : mx_a;
    assign mn   = (ph_w < mn_a) ? ph_w : mn_a;
    assign mid  = sat((DW+2)'(mx) + (DW+2)'(mn));

    // Drop the offset in sinusoidal mode
    always_comb
    begin
        if (in_ctrl.mode)
        begin
            offset_next = -(mid >>> 1);
        end
        else
        begin
            offset_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_ctrl_reg <= '0;
        end
        else
        begin
            s3_ctrl_reg <= in_ctrl;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_u_reg      <= ph_u;
        s3_v_reg      <= ph_v;
        s3_w_reg      <= ph_w;
        s3_offset_reg <= offset_next;
    end

    assign out_ctrl = s3_ctrl_reg;
    assign out_u    = s3_u_reg;
    assign out_v    = s3_v_reg;
    assign out_w    = s3_w_reg;
    assign offset   = s3_offset_reg;

endmodule

>>> src/tpdm_duty.sv
// Duty stage: add offset and one half, clamp to [0, 1), rescale to Q0.15.
// Depends on tpdm_pkg.
`timescale 1ns / 1ps

module tpdm_duty #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tpdm_pkg::stage_ctrl_t         in_ctrl,
    input  logic signed [DATA_WIDTH-1:0]  ph_u,
    input  logic signed [DATA_WIDTH-1:0]  ph_v,
    input  logic signed [DATA_WIDTH-1:0]  ph_w,
    input  logic signed [DATA_WIDTH-1:0]  offset,
    output logic                          done,
    output tpdm_pkg::duty_t               duty
);

    localparam int DW = DATA_WIDTH;
    localparam int UP = (DW >= 16) ? DW - 16 : 0;
    localparam int DN = (DW >= 16) ? 0 : 16 - DW;
    localparam logic signed [DW+1:0] SMAX_X = {3'b000, {(DW-1){1'b1}}};
    localparam logic signed [DW+1:0] SMIN_X = {3'b111, {(DW-1){1'b0}}};
    localparam logic signed [DW+1:0] HALF_X = {4'b0001, {(DW-2){1'b0}}};

    function automatic logic signed [DW-1:0] sat(input logic signed [DW+1:0] x);
        logic signed [DW+1:0] y;
        begin
            if (x > SMAX_X)
            begin
                y = SMAX_X;
            end
            else if (x < SMIN_X)
            begin
                y = SMIN_X;
            end
            else
            begin
                y = x;
            end
            return DW'(y);
        end
    endfunction

    // Offset, then half, each saturating; negative clamps to zero
    function automatic logic [14:0] to_duty(input logic signed [DW-1:0] ph,
                                            input logic signed [DW-1:0] off);
        logic signed [DW-1:0] d1;
        logic signed [DW-1:0] d2;
        logic [DW-1:0]        c;
        logic [DW+15:0]       scaled;
        begin
            d1     = sat((DW+2)'(ph) + (DW+2)'(off));
            d2     = sat((DW+2)'(d1) + HALF_X);
            c      = d2[DW-1] ? '0 : DW'(d2);
            scaled = ((DW+16)'(c) << DN) >> UP;
            return scaled[14:0];
        end
    endfunction

    logic            done_reg;
    tpdm_pkg::duty_t duty_reg;
    tpdm_pkg::duty_t duty_next;

    always_comb
    begin
        duty_next.duty_u = to_duty(ph_u, offset);
        duty_next.duty_v = to_duty(ph_v, offset);
        duty_next.duty_w = to_duty(ph_w, offset);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_ctrl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        duty_reg <= duty_next;
    end

    assign done = done_reg;
    assign duty = duty_reg;

endmodule

>>> src/three_phase_duty_modulator_unit.sv
// Channel  | Handshake          | Word
// ---------+--------------------+--------------------------------------------
// command  | start, busy        | vec   (tpdm_pkg::voltage_t: alpha, beta)
// result   | done (strobe)      | duty  (tpdm_pkg::duty_t: u, v, w duties)
// config   | cfg_write          | cfg_data (modulation mode, 1 = space vector)
//
// An accepted start reaches done through the four register stages (scale
// and multiply, Clarke sums, min/max offset, duty clamp); one word enters
// per cycle, so throughput is 1 word per cycle, as busy is never raised.
// busy stays low: the result strobe cannot be held off and the pipeline
// never stalls. Reset (rst_n, async) clears stage valid bits and sets
// the mode to space vector. Top level; depends on tpdm_pkg and the tpdm_* stages.
`timescale 1ns / 1ps

module three_phase_duty_modulator_unit #(
    parameter int DATA_WIDTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  tpdm_pkg::voltage_t vec,
    input  logic               cfg_write,
    input  logic               cfg_data,
    output logic               done,
    output tpdm_pkg::duty_t    duty
);

    logic                  mode_reg;
    logic                  mode_next;
    tpdm_pkg::stage_ctrl_t in_ctrl;
    tpdm_pkg::stage_ctrl_t clk_ctrl;
    tpdm_pkg::stage_ctrl_t inj_ctrl;

    logic signed [DATA_WIDTH-1:0] c_u;
    logic signed [DATA_WIDTH-1:0] c_v;
    logic signed [DATA_WIDTH-1:0] c_w;
    logic signed [DATA_WIDTH-1:0] i_u;
    logic signed [DATA_WIDTH-1:0] i_v;
    logic signed [DATA_WIDTH-1:0] i_w;
    logic signed [DATA_WIDTH-1:0] i_off;

    assign busy      = 1'b0;
    assign mode_next = cfg_write ? cfg_data : mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b1;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    // Carry the mode with each word down the pipeline
    assign in_ctrl.valid = start && !busy;
    assign in_ctrl.mode  = mode_reg;

    tpdm_clarke #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_clarke (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ctrl  (in_ctrl),
        .vec      (vec),
        .out_ctrl (clk_ctrl),
        .ph_u     (c_u),
        .ph_v     (c_v),
        .ph_w     (c_w)
    );

    tpdm_inject #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_inject (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ctrl  (clk_ctrl),
        .ph_u     (c_u),
        .ph_v     (c_v),
        .ph_w     (c_w),
        .out_ctrl (inj_ctrl),
        .out_u    (i_u),
        .out_v    (i_v),
        .out_w    (i_w),
        .offset   (i_off)
    );

    tpdm_duty #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_duty (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ctrl (inj_ctrl),
        .ph_u    (i_u),
        .ph_v    (i_v),
        .ph_w    (i_w),
        .offset  (i_off),
        .done    (done),
        .duty    (duty)
    );

endmodule

>>> src/tpdm_checker.sv
// Port-level checker for the three-phase duty modulator, bound to the top.
// Depends on tpdm_pkg and three_phase_duty_modulator_unit_assert.svh.
`timescale 1ns / 1ps
`include "three_phase_duty_modulator_unit_assert.svh"

module tpdm_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input tpdm_pkg::voltage_t vec,
    input logic               cfg_write,
    input logic               done,
    input tpdm_pkg::duty_t    duty
);

    logic accepted;
    logic zero_vec;
    logic centered;

    assign accepted = start && !busy;
    assign zero_vec = (vec.voltage_alpha == 16'sd0) && (vec.voltage_beta == 16'sd0);
    assign centered = (duty.duty_u == 15'd16384) && (duty.duty_v == 15'd16384) &&
                      (duty.duty_w == 15'd16384);

    // Every accepted word gives one strobe after the fixed latency
    `TPDM_ASSERT_DELAY(a_done_follows, clk, rst_n, accepted, 4, done)
    // No strobe without a word accepted that many cycles earlier
    `TPDM_ASSERT_DELAY(a_no_spurious, clk, rst_n, !accepted, 4, !done)
    // A zero vector lands at half duty on all phases in either mode
    `TPDM_ASSERT_DELAY(a_zero_center, clk, rst_n, accepted && zero_vec, 4, centered)
    // The pipeline never back-pressures, config writes included
    `TPDM_ASSERT_SAME(a_never_busy, clk, rst_n, cfg_write || !cfg_write, !busy)

endmodule

bind three_phase_duty_modulator_unit tpdm_checker u_tpdm_checker (.*);
